### rtl/core/icvt_pkg.sv
// Package for the infix to postfix converter.
// Holds the operator codes, error codes, sequencer states and character helpers.
// Has no dependencies; every other file of the block but icvt_stack_mem imports it.
`timescale 1ns / 1ps

package icvt_pkg;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LPAREN = 3'd1,
        OP_ADD    = 3'd2,
        OP_SUB    = 3'd3,
        OP_MUL    = 3'd4,
        OP_DIV    = 3'd5
    } op_code_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_CLOSE      = 2'd1,
        ERR_OVERFLOW   = 2'd2,
        ERR_OPEN_LEFT  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FLUSH
    } state_t;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;

    function automatic op_code_t code_of(input logic [7:0] c);
        op_code_t r;
        case (c)
            CH_LPAREN: r = OP_LPAREN;
            CH_ADD:    r = OP_ADD;
            CH_SUB:    r = OP_SUB;
            CH_MUL:    r = OP_MUL;
            CH_DIV:    r = OP_DIV;
            default:   r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] char_of(input logic [2:0] code);
        logic [7:0] r;
        case (code)
            OP_LPAREN: r = CH_LPAREN;
            OP_ADD:    r = CH_ADD;
            OP_SUB:    r = CH_SUB;
            OP_MUL:    r = CH_MUL;
            OP_DIV:    r = CH_DIV;
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] prio(input logic [2:0] code);
        logic [1:0] r;
        if (code >= 3'd4)
        begin
            r = 2'd3;
        end
        else if (code >= 3'd2)
        begin
            r = 2'd2;
        end
        else if (code == 3'd1)
        begin
            r = 2'd1;
        end
        else
        begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

### rtl/core/icvt_stack_mem.sv
// Operator stack storage: one write port and one registered read port.
// A write to the address being read is forwarded to the read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module icvt_stack_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [2:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [2:0]    rdata
);

    logic [2:0] mem [0:DEPTH-1];
    logic [2:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/icvt_ctrl.sv
// Sequencer of the converter: takes characters, reads and updates the stack
// memory one entry a cycle while the output is not stalled and drives the registered output beat.
// Depends on icvt_pkg.
`timescale 1ns / 1ps

module icvt_ctrl #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    in_char,
    input  logic          expr_last,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    out_char,
    output logic          has_char,
    output logic          run_last,
    output logic          expr_end,
    output icvt_pkg::err_t error,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [2:0]    mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [2:0]    mem_rdata
);

    import icvt_pkg::*;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        open_reg, open_next;
    logic        pend_reg, pend_next;
    logic [7:0]  pend_char_reg, pend_char_next;

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        out_has_reg;
    logic        out_rlast_reg;
    logic        out_end_reg;
    err_t        out_err_reg;

    logic        emit_req;
    logic [7:0]  e_char;
    logic        e_has;
    logic        e_rlast;
    logic        e_end;
    err_t        e_err;
    logic        done;
    logic        stall;
    logic        out_free;
    logic        accept;
    logic        nonempty;
    logic        full;
    op_code_t    cur_code;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] count_inc;

    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign nonempty  = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign cur_code  = code_of(char_reg);
    assign count_dec = count_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    // A popped operator is held back in pend_char_reg until it is known whether it
    // is the last beat caused by the character.
    always_comb
    begin
        emit_req       = 1'b0;
        e_char         = 8'h00;
        e_has          = 1'b0;
        e_rlast        = 1'b0;
        e_end          = 1'b0;
        e_err          = ERR_NONE;
        done           = 1'b0;
        count_next     = count_reg;
        open_next      = open_reg;
        pend_next      = pend_reg;
        pend_char_next = pend_char_reg;
        mem_we         = 1'b0;
        mem_wdata      = cur_code;
        case (state_reg)
            ST_IDLE:
            begin
                open_next = 1'b0;
            end
            ST_LOOK:
            begin
                if (char_reg == CH_RPAREN)
                begin
                    if (!nonempty)
                    begin
                        emit_req = 1'b1;
                        if (pend_reg)
                        begin
                            e_char    = pend_char_reg;
                            e_has     = 1'b1;
                            pend_next = 1'b0;
                        end
                        else
                        begin
                            e_err = ERR_CLOSE;
                            done  = 1'b1;
                        end
                    end
                    else if (mem_rdata == OP_LPAREN)
                    begin
                        emit_req   = pend_reg;
                        e_char     = pend_char_reg;
                        e_has      = 1'b1;
                        pend_next  = 1'b0;
                        count_next = count_dec;
                        done       = 1'b1;
                    end
                    else
                    begin
                        emit_req       = pend_reg;
                        e_char         = pend_char_reg;
                        e_has          = 1'b1;
                        pend_next      = 1'b1;
                        pend_char_next = char_of(mem_rdata);
                        count_next     = count_dec;
                    end
                end
                else if (cur_code != OP_NONE)
                begin
                    if ((cur_code != OP_LPAREN) && nonempty
                        && (prio(mem_rdata) >= prio(cur_code)))
                    begin
                        emit_req       = pend_reg;
                        e_char         = pend_char_reg;
                        e_has          = 1'b1;
                        pend_next      = 1'b1;
                        pend_char_next = char_of(mem_rdata);
                        count_next     = count_dec;
                    end
                    else if (full)
                    begin
                        emit_req = 1'b1;
                        e_err    = ERR_OVERFLOW;
                        done     = 1'b1;
                    end
                    else
                    begin
                        emit_req   = pend_reg;
                        e_char     = pend_char_reg;
                        e_has      = 1'b1;
                        pend_next  = 1'b0;
                        mem_we     = 1'b1;
                        count_next = count_inc;
                        done       = 1'b1;
                    end
                end
                else
                begin
                    emit_req = 1'b1;
                    e_char   = char_reg;
                    e_has    = 1'b1;
                    done     = 1'b1;
                end
                e_rlast = done && !last_reg;
            end
            ST_FLUSH:
            begin
                if (nonempty)
                begin
                    count_next = count_dec;
                    if (mem_rdata == OP_LPAREN)
                    begin
                        open_next = 1'b1;
                    end
                    else
                    begin
                        emit_req = 1'b1;
                        e_char   = char_of(mem_rdata);
                        e_has    = 1'b1;
                    end
                end
                else
                begin
                    emit_req = 1'b1;
                    e_end    = 1'b1;
                    e_rlast  = 1'b1;
                    e_err    = open_reg ? ERR_OPEN_LEFT : ERR_NONE;
                    done     = 1'b1;
                end
            end
            default:
            begin
                open_next = open_reg;
            end
        endcase
        stall = emit_req && !out_free;
        if (stall)
        begin
            count_next     = count_reg;
            open_next      = open_reg;
            pend_next      = pend_reg;
            pend_char_next = pend_char_reg;
            mem_we         = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (done && !stall)
                begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (done && !stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_waddr = AW'(count_reg);
    assign mem_raddr = (count_next == '0) ? '0 : AW'(count_next - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            open_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            open_reg  <= open_next;
            pend_reg  <= pend_next;
            if (emit_req && !stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
        if (accept)
        begin
            char_reg <= in_char;
            last_reg <= expr_last;
        end
        if (emit_req && !stall)
        begin
            out_char_reg  <= e_char;
            out_has_reg   <= e_has;
            out_rlast_reg <= e_rlast;
            out_end_reg   <= e_end;
            out_err_reg   <= e_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_char = out_char_reg;
    assign has_char = out_has_reg;
    assign run_last = out_rlast_reg;
    assign expr_end = out_end_reg;
    assign error    = out_err_reg;

endmodule

### rtl/core/infix_to_postfix_converter_unit.sv
// Top level of the infix to postfix converter.
// Instantiates icvt_ctrl and icvt_stack_mem; depends on icvt_pkg.
// Converts an infix character stream to postfix order with an operator stack
// held in a synchronous memory. A character is handled in the cycle after it
// is taken, once the top of stack has been read. Operators are popped from
// the stack one entry per cycle while no beat is held back, an unmatched
// closing bracket ends with an error beat, and an expression end empties the
// stack and adds a closing status beat. A beat that cannot leave the output
// register holds the sequencer until it is taken. The stack needs no clearing
// after reset; results wait in an output register so that the next character
// is taken while a result is still held.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [8] expr_end, [10:9] error, rest zero
    output logic        m_tuser,   // [0] has_char
    output logic        m_tlast
);

    import icvt_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [2:0]    mem_rdata;
    logic [7:0]    out_char;
    logic          expr_end;
    err_t          error;

    icvt_ctrl #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_char   (s_tdata),
        .expr_last (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_char  (out_char),
        .has_char  (m_tuser),
        .run_last  (m_tlast),
        .expr_end  (expr_end),
        .error     (error),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    icvt_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = {5'b0, error, expr_end, out_char};

endmodule

### tb/infix_to_postfix_converter_unit_checker.sv
// Checker for the infix to postfix converter: watches both streams and predicts the results.
// Keeps its own operator stack and compares every output beat with the oldest prediction.
// Depends on icvt_pkg for the operator codes, error codes and character constants.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] out_char, [8] expr_end, [10:9] error, rest zero
    input  logic        m_tuser,   // [0] has_char
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    import icvt_pkg::*;

    typedef struct {
        logic [7:0] out_char;
        logic       has_char;
        logic       run_last;
        logic       expr_end;
        err_t       error;
    } postfix_beat_t;

    postfix_beat_t postfix_due[$];
    op_code_t      held_ops[STACK_DEPTH];
    int            held_count;

    function automatic op_code_t classify_char(input logic [7:0] c);
        case (c)
            CH_LPAREN: return OP_LPAREN;
            CH_ADD:    return OP_ADD;
            CH_SUB:    return OP_SUB;
            CH_MUL:    return OP_MUL;
            CH_DIV:    return OP_DIV;
            default:   return OP_NONE;
        endcase
    endfunction

    function automatic int binding_of(input op_code_t op);
        case (op)
            OP_MUL, OP_DIV: return 3;
            OP_ADD, OP_SUB: return 2;
            OP_LPAREN:      return 1;
            default:        return 0;
        endcase
    endfunction

    function automatic postfix_beat_t make_beat(input logic [7:0] c, input logic has,
                                                input logic fin, input err_t err);
        postfix_beat_t b;
        b.out_char = c;
        b.has_char = has;
        b.run_last = 1'b0;
        b.expr_end = fin;
        b.error    = err;
        return b;
    endfunction

    function automatic op_code_t pop_op();
        held_count--;
        return held_ops[held_count];
    endfunction

    function automatic logic [7:0] symbol_of(input op_code_t op);
        case (op)
            OP_ADD:  return CH_ADD;
            OP_SUB:  return CH_SUB;
            OP_MUL:  return CH_MUL;
            OP_DIV:  return CH_DIV;
            default: return 8'h00;
        endcase
    endfunction

    function automatic void convert_char(input logic [7:0] c, input logic fin);
        postfix_beat_t run[$];
        op_code_t      op;
        op_code_t      top;
        logic          open_left;
        op        = classify_char(c);
        open_left = 1'b0;
        if (c == CH_RPAREN)
        begin
            while (held_count > 0 && held_ops[held_count - 1] != OP_LPAREN)
            begin
                run.push_back(make_beat(symbol_of(pop_op()), 1'b1, 1'b0, ERR_NONE));
            end
            if (held_count > 0)
            begin
                held_count--;
            end
            else
            begin
                run.push_back(make_beat(8'h00, 1'b0, 1'b0, ERR_CLOSE));
            end
        end
        else if (op == OP_NONE)
        begin
            run.push_back(make_beat(c, 1'b1, 1'b0, ERR_NONE));
        end
        else
        begin
            if (op != OP_LPAREN)
            begin
                while (held_count > 0 && binding_of(held_ops[held_count - 1]) >= binding_of(op))
                begin
                    run.push_back(make_beat(symbol_of(pop_op()), 1'b1, 1'b0, ERR_NONE));
                end
            end
            if (held_count >= STACK_DEPTH)
            begin
                run.push_back(make_beat(8'h00, 1'b0, 1'b0, ERR_OVERFLOW));
            end
            else
            begin
                held_ops[held_count] = op;
                held_count++;
            end
        end
        if (fin)
        begin
            while (held_count > 0)
            begin
                top = pop_op();
                if (top == OP_LPAREN)
                begin
                    open_left = 1'b1;
                end
                else
                begin
                    run.push_back(make_beat(symbol_of(top), 1'b1, 1'b0, ERR_NONE));
                end
            end
            run.push_back(make_beat(8'h00, 1'b0, 1'b1, open_left ? ERR_OPEN_LEFT : ERR_NONE));
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].run_last = 1'b1;
        end
        foreach (run[i])
        begin
            postfix_due.push_back(run[i]);
        end
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        postfix_beat_t want;
        if (!rst_n)
        begin
            postfix_due.delete();
            held_count = 0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (postfix_due.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, got data %0h user %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = postfix_due.pop_front();
                    compare_field("out_char", want.out_char, m_tdata[7:0]);
                    compare_field("has_char", 8'(want.has_char), 8'(m_tuser));
                    compare_field("run_last", 8'(want.run_last), 8'(m_tlast));
                    compare_field("expr_end", 8'(want.expr_end), 8'(m_tdata[8]));
                    compare_field("error", 8'(want.error), 8'(m_tdata[10:9]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                convert_char(s_tdata, s_tlast);
            end
            pending = postfix_due.size();
        end
    end

endmodule

### tb/infix_to_postfix_converter_unit_test.sv
// Testbench top for the infix to postfix converter: clock, reset, stimulus and verdict.
// Sends directed and random expressions with bursty input and a stalling output side.
// Depends on icvt_pkg, the block itself and infix_to_postfix_converter_unit_checker.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_test;
    import icvt_pkg::*;

    localparam int STACK_DEPTH  = 32;
    localparam int ITEM_TARGET  = 360;
    localparam int STALL_LIMIT  = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          rx_left     = 0;
    logic        rx_ready    = 1'b0;
    int          items_sent  = 0;
    logic [7:0]  expr_text[$];

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] in_char
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_char, [8] expr_end, [10:9] error, rest zero
        .m_tuser  (m_tuser),   // [0] has_char
        .m_tlast  (m_tlast)
    );

    infix_to_postfix_converter_unit_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // The output side alternates short stalls with ready stretches, now and then a long one.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                rx_ready = 1'b1;
                rx_left  = $urandom_range(40, 120);
            end
            else
            begin
                rx_ready = ($urandom_range(0, 2) != 0);
                rx_left  = rx_ready ? $urandom_range(1, 10) : $urandom_range(1, 12);
            end
        end
        rx_left--;
        m_tready <= rx_ready;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** infix_to_postfix_converter_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_expr();
        foreach (expr_text[i])
        begin
            send_beat(expr_text[i], i == expr_text.size() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        burst_left = 0;
    endtask

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
        begin
            return 8'h61 + 8'($urandom_range(0, 25));
        end
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_LPAREN, CH_RPAREN, CH_MUL, CH_ADD, CH_SUB, CH_DIV});
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    function automatic void build_sound();
        int open_cnt;
        int terms;
        int max_terms;
        open_cnt  = 0;
        terms     = 0;
        max_terms = $urandom_range(1, 6);
        do
        begin
            while (open_cnt < 4 && $urandom_range(0, 3) == 0)
            begin
                expr_text.push_back(CH_LPAREN);
                open_cnt++;
            end
            expr_text.push_back(pick_operand());
            terms++;
            while (open_cnt > 0 && $urandom_range(0, 2) == 0)
            begin
                expr_text.push_back(CH_RPAREN);
                open_cnt--;
            end
            if (terms < max_terms)
            begin
                expr_text.push_back(pick_operator());
            end
        end
        while (terms < max_terms);
        repeat (open_cnt) expr_text.push_back(CH_RPAREN);
    endfunction

    // Nesting near the depth of the operator stack, which may fill it, with operators between some brackets.
    function automatic void build_deep();
        int depth;
        depth = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
        for (int i = 0; i < depth; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                expr_text.push_back(pick_operand());
                expr_text.push_back(pick_operator());
            end
            expr_text.push_back(CH_LPAREN);
        end
        expr_text.push_back(pick_operand());
        repeat ($urandom_range(0, depth)) expr_text.push_back(CH_RPAREN);
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                expr_text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       expr_text.push_back(CH_LPAREN);
                    1:       expr_text.push_back(CH_RPAREN);
                    default: expr_text.push_back(pick_operator());
                endcase
            end
        end
    endfunction

    function automatic void build_broken();
        int pos;
        build_sound();
        pos = $urandom_range(0, expr_text.size() - 1);
        case ($urandom_range(0, 2))
            0: expr_text.insert(pos, CH_RPAREN);
            1: expr_text.insert(pos, CH_LPAREN);
            default:
            begin
                if (expr_text.size() > 1)
                begin
                    expr_text.delete(pos);
                end
            end
        endcase
    endfunction

    initial
    begin
        int  pick;
        logic half_drained;
        half_drained = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_text("a+b*c");
        send_text("(p-q)/r*s");
        send_text("-");
        send_beat(CH_RPAREN, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_text("a*b)");
        send_beat(CH_LPAREN, 1'b0);
        send_beat(8'h00, 1'b1);
        wait_drained();

        expr_text.delete();
        build_deep();
        send_expr();

        while (items_sent < ITEM_TARGET)
        begin
            if (!half_drained && items_sent >= ITEM_TARGET / 2)
            begin
                wait_drained();
                half_drained = 1'b1;
            end
            expr_text.delete();
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                build_sound();
            end
            else if (pick < 85)
            begin
                build_noise();
            end
            else if (pick < 95)
            begin
                build_broken();
            end
            else
            begin
                build_deep();
            end
            send_expr();
        end

        wait_drained();
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("** infix_to_postfix_converter_unit: PASSED **");
        end
        else
        begin
            $display("** infix_to_postfix_converter_unit: FAILED **");
        end
        $finish;
    end

endmodule
